@@ hdl/pinhole_backproject_to_world_top_macros.svh @@
// Assertion macros used by the back-projection top level.
`ifndef PINHOLE_BACKPROJECT_TO_WORLD_TOP_MACROS_SVH
`define PINHOLE_BACKPROJECT_TO_WORLD_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define PBW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define PBW_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PBW_ASSERT(lbl, clk, rst_n, prop, msg)
`define PBW_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ hdl/pbw_pkg.sv @@
// Shared types and constants of the back-projection block.
package pbw_pkg;
    localparam int DIV_STAGES = 61;
    localparam int NUM_W      = 61;
    localparam int REM_W      = 25;

    localparam logic [3:0] REG_FOCAL_X = 4'd0;
    localparam logic [3:0] REG_FOCAL_Y = 4'd1;
    localparam logic [3:0] REG_CENTER_X = 4'd2;
    localparam logic [3:0] REG_CENTER_Y = 4'd3;
    localparam logic [3:0] REG_ROT_ROW0 = 4'd4;
    localparam logic [3:0] REG_ROT_ROW1 = 4'd5;
    localparam logic [3:0] REG_ROT_ROW2 = 4'd6;
    localparam logic [3:0] REG_TRANS    = 4'd7;

    typedef struct packed {
        logic               ok;
        logic               neg_x;
        logic [42:0]        prod_x;
        logic               neg_y;
        logic [42:0]        prod_y;
        logic signed [23:0] depth;
    } t_front_word;

    typedef struct packed {
        logic               ok;
        logic signed [23:0] depth;
    } t_side;
endpackage

@@ hdl/pbw_front.sv @@
// Front end: offset from principal point, depth check, offset times depth.
module pbw_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [15:0]          i_pixel_x,
    input  logic [15:0]          i_pixel_y,
    input  logic signed [23:0]   i_depth_mm,
    input  logic [19:0]          i_center_x,
    input  logic [19:0]          i_center_y,
    output logic                 o_push,
    output pbw_pkg::t_front_word o_word
);
    import pbw_pkg::*;

    logic               r_v1, r_ok1, r_negx1, r_negy1;
    logic [19:0]        r_magx1, r_magy1;
    logic signed [23:0] r_d1;
    logic [20:0]        off_x, off_y;
    logic               r_v2;
    t_front_word        r_w2;

    assign off_x = {1'b0, i_pixel_x, 4'b0} - {1'b0, i_center_x};
    assign off_y = {1'b0, i_pixel_y, 4'b0} - {1'b0, i_center_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok1   <= !i_depth_mm[23] && (i_depth_mm != 24'sd0);
        r_negx1 <= off_x[20];
        r_negy1 <= off_y[20];
        r_magx1 <= off_x[20] ? 20'(-off_x) : off_x[19:0];
        r_magy1 <= off_y[20] ? 20'(-off_y) : off_y[19:0];
        r_d1    <= i_depth_mm;

        r_w2.ok     <= r_ok1;
        r_w2.neg_x  <= r_negx1;
        r_w2.neg_y  <= r_negy1;
        r_w2.depth  <= r_d1;
        r_w2.prod_x <= r_ok1 ? 43'(r_magx1 * r_d1[22:0]) : 43'd0;
        r_w2.prod_y <= r_ok1 ? 43'(r_magy1 * r_d1[22:0]) : 43'd0;
    end

    assign o_push = r_v2;
    assign o_word = r_w2;
endmodule

@@ hdl/pbw_fifo.sv @@
// Two-word queue between front end and back end.
module pbw_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  pbw_pkg::t_front_word i_word,
    input  logic                 i_pop,
    output pbw_pkg::t_front_word o_word,
    output logic                 o_empty,
    output logic                 o_full
);
    import pbw_pkg::*;

    t_front_word r_mem [2];
    logic        r_wr, r_rd;
    logic [1:0]  r_cnt;
    logic        do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_word  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= !r_wr;
            if (do_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule

@@ hdl/pbw_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, rounds to nearest.
module pbw_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [58:0]        i_num,
    input  logic               i_neg,
    input  logic [23:0]        i_focal,
    output logic               o_vld,
    output logic signed [60:0] o_pc
);
    import pbw_pkg::*;

    logic [23:0]         f_eff;
    logic [REM_W-1:0]    den;
    logic [NUM_W-1:0]    n0;
    logic [NUM_W-1:0]    r_n   [DIV_STAGES];
    logic [NUM_W-1:0]    r_q   [DIV_STAGES];
    logic [REM_W-1:0]    r_rem [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_neg, r_vld;
    logic               r_ovld;
    logic signed [60:0] r_pc;

    // a zero focal length counts as one LSB
    assign f_eff = (i_focal == 24'd0) ? 24'd1 : i_focal;
    assign den   = {f_eff, 1'b0};
    assign n0    = {1'b0, i_num, 1'b0} + NUM_W'(f_eff);

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [NUM_W-1:0] n_in, q_in, q_out;
        logic             neg_in, vld_in;
        logic [REM_W:0]   trial;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign n_in   = n0;
            assign q_in   = '0;
            assign neg_in = i_neg;
            assign vld_in = i_vld;
        end else begin : g_rest
            assign rem_in = r_rem[k-1];
            assign n_in   = r_n[k-1];
            assign q_in   = r_q[k-1];
            assign neg_in = r_neg[k-1];
            assign vld_in = r_vld[k-1];
        end

        assign trial = {rem_in, n_in[NUM_W-1-k]};
        assign take  = (trial >= {1'b0, den});

        always_comb begin
            q_out = q_in;
            q_out[NUM_W-1-k] = take;
        end

        always_ff @(posedge i_clk) begin
            r_n[k]   <= n_in;
            r_q[k]   <= q_out;
            r_neg[k] <= neg_in;
            r_rem[k] <= take ? REM_W'(trial - {1'b0, den}) : trial[REM_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc <= r_neg[DIV_STAGES-1] ? -$signed(r_q[DIV_STAGES-1])
                                    : $signed(r_q[DIV_STAGES-1]);
    end

    assign o_vld = r_ovld;
    assign o_pc  = r_pc;
endmodule

@@ hdl/pbw_back.sv @@
// Back end: divide by focal length, rotate, translate, round and saturate.
module pbw_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  pbw_pkg::t_front_word i_word,
    input  logic [23:0]          i_focal_x,
    input  logic [23:0]          i_focal_y,
    input  logic [53:0]          i_rot_row0,
    input  logic [53:0]          i_rot_row1,
    input  logic [53:0]          i_rot_row2,
    input  logic [62:0]          i_trans,
    output logic                 o_strobe,
    output logic signed [31:0]   o_world_x,
    output logic signed [31:0]   o_world_y,
    output logic signed [31:0]   o_world_z,
    output logic                 o_point_valid,
    output logic                 o_saturated
);
    import pbw_pkg::*;

    logic               vx, vy;
    logic signed [60:0] pcx, pcy;
    t_side              r_side [DIV_STAGES+1];
    t_side              side_out;
    logic signed [60:0] pc [3];
    logic [53:0]        rows [3];

    logic               r_v_m1, r_v_m2, r_v_a1, r_v_a2, r_v_o;
    logic               r_ok_m1, r_ok_m2, r_ok_a1, r_ok_a2;
    logic signed [48:0] r_lo [3][3];
    logic signed [48:0] r_hi [3][3];
    logic signed [80:0] r_p  [3][3];
    logic signed [80:0] r_s01 [3];
    logic signed [80:0] r_s2t [3];
    logic signed [80:0] r_acc [3];
    logic signed [80:0] rnd [3];
    logic signed [31:0] res [3];
    logic [2:0]         clip;
    logic signed [31:0] r_out [3];
    logic               r_ok_o, r_sat_o;

    pbw_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(i_vld),
        .i_num({i_word.prod_x, 16'b0}), .i_neg(i_word.neg_x), .i_focal(i_focal_x),
        .o_vld(vx), .o_pc(pcx)
    );

    pbw_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(i_vld),
        .i_num({i_word.prod_y, 16'b0}), .i_neg(i_word.neg_y), .i_focal(i_focal_y),
        .o_vld(vy), .o_pc(pcy)
    );

    // carry depth alongside the dividers
    always_ff @(posedge i_clk) begin
        r_side[0] <= '{ok: i_word.ok, depth: i_word.depth};
        for (int k = 1; k < DIV_STAGES + 1; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end
    assign side_out = r_side[DIV_STAGES];

    assign pc[0] = pcx;
    assign pc[1] = pcy;
    assign pc[2] = {{21{side_out.depth[23]}}, side_out.depth, 16'b0};
    assign rows[0] = i_rot_row0;
    assign rows[1] = i_rot_row1;
    assign rows[2] = i_rot_row2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_m1 <= 1'b0;
            r_v_m2 <= 1'b0;
            r_v_a1 <= 1'b0;
            r_v_a2 <= 1'b0;
            r_v_o  <= 1'b0;
        end else begin
            r_v_m1 <= vx && vy;
            r_v_m2 <= r_v_m1;
            r_v_a1 <= r_v_m2;
            r_v_a2 <= r_v_a1;
            r_v_o  <= r_v_a2;
        end
    end

    // split each 61x18 product into two 31x18 halves
    always_ff @(posedge i_clk) begin
        r_ok_m1 <= side_out.ok;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_lo[i][j] <= $signed({1'b0, pc[j][29:0]}) * $signed(rows[i][18*j +: 18]);
                r_hi[i][j] <= $signed(pc[j][60:30]) * $signed(rows[i][18*j +: 18]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok_m2 <= r_ok_m1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_p[i][j] <= (81'(r_hi[i][j]) <<< 30) + 81'(r_lo[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok_a1 <= r_ok_m2;
        for (int i = 0; i < 3; i++) begin
            r_s01[i] <= r_p[i][0] + r_p[i][1];
            r_s2t[i] <= r_p[i][2] + (81'($signed(i_trans[21*i +: 21])) <<< 32);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok_a2 <= r_ok_a1;
        for (int i = 0; i < 3; i++) begin
            r_acc[i] <= r_s01[i] + r_s2t[i];
        end
    end

    // round half up to whole mm, then clip to 32 bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i]  = r_acc[i] + 81'sd2147483648;
            clip[i] = (rnd[i][80:63] != {18{rnd[i][80]}});
            if (clip[i]) begin
                res[i] = rnd[i][80] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
                res[i] = rnd[i][63:32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok_o  <= r_ok_a2;
        r_sat_o <= r_ok_a2 && (clip != 3'b000);
        for (int i = 0; i < 3; i++) begin
            r_out[i] <= r_ok_a2 ? res[i] : 32'sd0;
        end
    end

    assign o_strobe      = r_v_o;
    assign o_world_x     = r_out[0];
    assign o_world_y     = r_out[1];
    assign o_world_z     = r_out[2];
    assign o_point_valid = r_v_o && r_ok_o;
    assign o_saturated   = r_v_o && r_sat_o;
endmodule

@@ hdl/pinhole_backproject_to_world_top.sv @@
// Top level of the pinhole depth back-projection to world coordinates.
//
// Takes one word (pixel_x, pixel_y, depth_mm) per clock when start is high
// and busy is low, and returns one world point per word, in order. The point
// is on the result ports while o_res_strobe is high and is taken at the edge
// that ends the strobe cycle. The result path cannot be stalled: every
// strobe cycle is taken. Throughput is one word per clock. The two 61-stage
// pipelined dividers divide offset*depth by the focal lengths, one quotient
// bit per stage. The front end computes the pixel offset and offset*depth,
// a two-word queue decouples it from the back end, and the back end divides,
// rotates (split 61x18 multiplies), adds translation, rounds and saturates.
// A depth of zero or less gives point_valid=0 with all other fields zero.
// Configuration registers are written over the cfg channel, which is always
// ready; write them only while no word is in flight. Out-of-range indices
// are dropped.
module pinhole_backproject_to_world_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_pixel_x,
    input  logic [15:0]        i_pixel_y,
    input  logic signed [23:0] i_depth_mm,
    output logic               o_res_strobe,
    output logic signed [31:0] o_world_x,
    output logic signed [31:0] o_world_y,
    output logic signed [31:0] o_world_z,
    output logic               o_point_valid,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    import pbw_pkg::*;

`include "pinhole_backproject_to_world_top_macros.svh"

    logic [23:0] r_focal_x, r_focal_y;
    logic [19:0] r_center_x, r_center_y;
    logic [53:0] r_rot0, r_rot1, r_rot2;
    logic [62:0] r_trans;

    logic        accept, push, fifo_empty, fifo_full;
    t_front_word front_word, head_word;
    logic        invalid_out, out_zero;

    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    // hold off new words only if the queue ever fills
    assign busy        = fifo_full;

    // register file; reset pose is identity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= 24'd256;
            r_focal_y  <= 24'd256;
            r_center_x <= 20'd0;
            r_center_y <= 20'd0;
            r_rot0     <= 54'd65536;
            r_rot1     <= 54'd65536 << 18;
            r_rot2     <= 54'd65536 << 36;
            r_trans    <= 63'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FOCAL_X:  r_focal_x  <= i_cfg_data[23:0];
                REG_FOCAL_Y:  r_focal_y  <= i_cfg_data[23:0];
                REG_CENTER_X: r_center_x <= i_cfg_data[19:0];
                REG_CENTER_Y: r_center_y <= i_cfg_data[19:0];
                REG_ROT_ROW0: r_rot0     <= i_cfg_data[53:0];
                REG_ROT_ROW1: r_rot1     <= i_cfg_data[53:0];
                REG_ROT_ROW2: r_rot2     <= i_cfg_data[53:0];
                REG_TRANS:    r_trans    <= i_cfg_data[62:0];
                default: ;
            endcase
        end
    end

    pbw_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y), .i_depth_mm(i_depth_mm),
        .i_center_x(r_center_x), .i_center_y(r_center_y),
        .o_push(push), .o_word(front_word)
    );

    // the back end drains the queue every cycle it holds a word
    pbw_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_word(front_word),
        .i_pop(!fifo_empty), .o_word(head_word), .o_empty(fifo_empty),
        .o_full(fifo_full)
    );

    pbw_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(!fifo_empty), .i_word(head_word),
        .i_focal_x(r_focal_x), .i_focal_y(r_focal_y),
        .i_rot_row0(r_rot0), .i_rot_row1(r_rot1), .i_rot_row2(r_rot2),
        .i_trans(r_trans),
        .o_strobe(o_res_strobe), .o_world_x(o_world_x), .o_world_y(o_world_y),
        .o_world_z(o_world_z), .o_point_valid(o_point_valid),
        .o_saturated(o_saturated)
    );

    assign invalid_out = o_res_strobe && !o_point_valid;
    assign out_zero    = (o_world_x == 32'sd0) && (o_world_y == 32'sd0)
                         && (o_world_z == 32'sd0);

    `PBW_NEVER(a_queue_never_full, i_clk, i_rst_n, busy, "queue filled up")
    `PBW_NEVER(a_sat_needs_valid, i_clk, i_rst_n, o_saturated && !o_point_valid, "sat on invalid")
    `PBW_ASSERT(a_invalid_zero, i_clk, i_rst_n, invalid_out |-> out_zero, "invalid point not zero")
endmodule
